// ===== hw/rtl/aes128_block_cipher_defines.svh =====
// Assertion macros for the AES-128 block cipher.
// Used by aes128_block_cipher.sv; no other dependencies.
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH

// Assert an implication that holds on every clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert an implication whose consequent holds in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/aes128_pkg.sv =====
// Shared constants and functions for the AES-128 block cipher.
// No dependencies.
`timescale 1ns / 1ps
package aes128_pkg;
    localparam int ROUND_COUNT_DEF = 10;
    localparam int KEY_REG_COUNT = 2;
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;
    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] block_t;

    function automatic byte_t fwd_sbox(input byte_t a);
        byte_t t [256] = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic byte_t dec_sbox(input byte_t a);
        byte_t t [256] = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    // Forward MixColumns on one 32-bit column, byte 0 in the top bits.
    function automatic logic [31:0] mix_fwd(input logic [31:0] c);
        byte_t a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // Inverse MixColumns: premultiply by {04,00,05,00} then forward mix.
    function automatic logic [31:0] mix_inv(input logic [31:0] c);
        byte_t a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction
endpackage

// ===== hw/rtl/aes128_block_cipher.sv =====
// AES-128 ECB cipher top level: key schedule memory, round unit, control.
// Depends on aes128_pkg and aes128_block_cipher_defines.svh.
`timescale 1ns / 1ps
`include "aes128_block_cipher_defines.svh"
//
// Channel   Direction  Signals                              Transfer
// config    in         cfg_we, cfg_index, cfg_data          cfg_we high at clk
// command   in         start, op, block_high, block_low     start & !busy
// result    out        done, result_high, result_low        done high, one cycle
//
// An item runs thus: the start transfer also fetches the first round key,
// then the load state adds it and the rounds run one after another on the
// shared round unit, each round reading its key from the round key memory in
// the cycle before; done is registered after the last round and the next start
// is taken at the edge that ends it. A key write starts the key expansion (one
// word per cycle); busy is held meanwhile. Reset clears control; the key memory
// is not cleared. The receiver cannot stall: done is a single-cycle strobe.
module aes128_block_cipher
    import aes128_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        done,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    localparam int RK_WORDS = 4 * (ROUND_COUNT + 1);
    localparam int AW = $clog2(RK_WORDS);
    localparam int RW = $clog2(ROUND_COUNT + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXP  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [63:0]  key_high_reg, key_low_reg;
    logic [127:0] rk_mem [ROUND_COUNT + 1];
    logic [AW-1:0] exp_idx_reg;
    logic [127:0] win_reg;
    logic [7:0]   rcon_reg;
    logic [RW-1:0] round_reg;
    logic         op_reg;
    logic [127:0] st_reg;
    logic [127:0] rk_rd_reg;
    logic [RW-1:0] rd_round;
    logic         done_reg;
    logic [127:0] res_reg;

    // Memory stores one round key per row; index RK row = word / 4.
    // Row writes during expansion happen one word at a time via shift window.
    logic [31:0]  new_word;
    logic [31:0]  tw;
    logic         word_first;

    assign word_first = (exp_idx_reg[1:0] == 2'd0);
    always_comb
    begin
        tw = win_reg[31:0];
        if (word_first)
        begin
            tw = {fwd_sbox(tw[23:16]), fwd_sbox(tw[15:8]), fwd_sbox(tw[7:0]),
                  fwd_sbox(tw[31:24])} ^ {rcon_reg, 24'h0};
        end
        new_word = win_reg[127:96] ^ tw;
    end

    // Control state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_LOAD;
            ST_EXP:  if (exp_idx_reg == AW'(RK_WORDS - 1)) state_next = ST_IDLE;
            ST_LOAD: state_next = ST_RUN;
            ST_RUN:  if (round_reg == RW'(ROUND_COUNT)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we) state_next = ST_EXP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            done_reg     <= 1'b0;
            exp_idx_reg  <= '0;
            round_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_RUN) && (round_reg == RW'(ROUND_COUNT));
            if (cfg_we)
            begin
                exp_idx_reg <= AW'(4);
                if (cfg_index == CFG_KEY_HIGH) key_high_reg <= cfg_data;
                else                           key_low_reg  <= cfg_data;
            end
            else if (state_reg == ST_EXP)
            begin
                exp_idx_reg <= exp_idx_reg + AW'(1);
            end
            if (state_reg == ST_LOAD) round_reg <= RW'(1);
            else if (state_reg == ST_RUN) round_reg <= round_reg + RW'(1);
        end
    end

    // Expansion window: last four words, rcon advance
    logic [127:0] key_now;
    assign key_now = (cfg_index == CFG_KEY_HIGH) ? {cfg_data, key_low_reg}
                                                 : {key_high_reg, cfg_data};
    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            win_reg  <= key_now;
            rcon_reg <= RCON_FIRST;
        end
        else if (state_reg == ST_EXP)
        begin
            win_reg <= {win_reg[95:0], new_word};
            if (exp_idx_reg[1:0] == 2'd0) rcon_reg <= xtime(rcon_reg);
        end
    end

    // Round key memory: one row per round, written when a row completes
    logic         mem_we;
    logic [RW-1:0] mem_wa;
    logic [127:0] mem_wd;
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = {win_reg[95:0], new_word};
        if (cfg_we)
        begin
            mem_we = 1'b1;
            mem_wd = key_now;
        end
        else if (state_reg == ST_EXP && exp_idx_reg[1:0] == 2'd3)
        begin
            mem_we = 1'b1;
            mem_wa = RW'(exp_idx_reg[AW-1:2]);
        end
    end

    // Key read address: one round ahead of the round unit
    always_comb
    begin
        rd_round = '0;
        if (state_reg == ST_IDLE)
            rd_round = (op == OP_ENCRYPT) ? '0 : RW'(ROUND_COUNT);
        else if (state_reg == ST_LOAD)
            rd_round = (op_reg == OP_ENCRYPT) ? RW'(1) : RW'(ROUND_COUNT - 1);
        else if (state_reg == ST_RUN && round_reg != RW'(ROUND_COUNT))
        begin
            if (op_reg == OP_ENCRYPT)
                rd_round = round_reg + RW'(1);
            else
                rd_round = RW'(ROUND_COUNT - 1) - round_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) rk_mem[mem_wa] <= mem_wd;
        rk_rd_reg <= rk_mem[rd_round];
    end

    // Round unit
    logic [127:0] sb, sr, mx, rout;
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sb[127-8*i -: 8] = (op_reg == OP_ENCRYPT) ? fwd_sbox(st_reg[127-8*i -: 8])
                                                      : dec_sbox(st_reg[127-8*i -: 8]);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sr[127-8*(4*c+k) -: 8] = (op_reg == OP_ENCRYPT)
                    ? sb[127-8*(4*((c+k)&3)+k) -: 8]
                    : sb[127-8*(4*((c+3*k)&3)+k) -: 8];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            if (op_reg == OP_ENCRYPT)
                mx[127-32*c -: 32] = mix_fwd(sr[127-32*c -: 32]);
            else
                mx[127-32*c -: 32] = mix_inv(sr[127-32*c -: 32] ^ rk_rd_reg[127-32*c -: 32]);
        end
        if (round_reg == RW'(ROUND_COUNT))
            rout = sr ^ rk_rd_reg;
        else if (op_reg == OP_ENCRYPT)
            rout = mx ^ rk_rd_reg;
        else
            rout = mx;
    end

    // Hold state, advance one round per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && !cfg_we)
        begin
            op_reg <= op;
            st_reg <= {block_high, block_low};
        end
        else if (state_reg == ST_LOAD)
            st_reg <= st_reg ^ rk_rd_reg;
        else if (state_reg == ST_RUN)
            st_reg <= rout;
        if (state_reg == ST_RUN && round_reg == RW'(ROUND_COUNT))
            res_reg <= rout;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign result_high = res_reg[127:64];
    assign result_low  = res_reg[63:0];

    `AES_ASSERT_NEXT(a_done_after_last, clk, rst_n,
        state_reg == ST_RUN && round_reg == RW'(ROUND_COUNT), done, "done missing")
    `AES_ASSERT_IMP(a_done_idle, clk, rst_n, done, state_reg != ST_RUN, "done while running")
    `AES_ASSERT_NEXT(a_start_load, clk, rst_n,
        state_reg == ST_IDLE && start && !cfg_we, state_reg == ST_LOAD, "start not taken")
    `AES_ASSERT_IMP(a_round_range, clk, rst_n, state_reg == ST_RUN,
        round_reg != '0, "round out of range")
endmodule

// ===== sim/tb_aes128_block_cipher.sv =====
// Self-checking testbench for the AES-128 ECB block cipher: a queued command driver,
// a result monitor, and a reference AES model that predicts each result.
// Depends on aes128_pkg and the aes128_block_cipher RTL.
`timescale 1ns / 1ps

module tb_aes128_block_cipher;
    import aes128_pkg::*;

    localparam int CLK_HALF = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int TAIL_CYCLES = 40;

    typedef enum logic [1:0] {CMD_BLOCK, CMD_KEY, CMD_DRAIN} cmd_kind_t;

    typedef struct {
        cmd_kind_t   kind;
        logic        op_bit;
        logic        reg_idx;
        logic [63:0] hi;
        logic [63:0] lo;
    } cmd_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_pair_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;
    logic        start;
    logic        busy;
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        done;
    logic [63:0] result_high;
    logic [63:0] result_low;

    cmd_t        pending_cmds[$];
    block_pair_t cipher_results_q[$];

    // Predictor state
    logic [7:0]  sub_tab[256];
    logic [7:0]  unsub_tab[256];
    logic [31:0] sched_words[44];
    logic [63:0] key_hi_shadow;
    logic [63:0] key_lo_shadow;
    logic [7:0]  st[16];

    int unsigned cycle_cnt;
    int unsigned blocks_sent;
    int unsigned results_seen;
    int unsigned key_writes;
    int unsigned error_cnt;
    int unsigned settle_cnt;

    aes128_block_cipher i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .block_high  (block_high),
        .block_low   (block_low),
        .done        (done),
        .result_high (result_high),
        .result_low  (result_low)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_HALF clk = ~clk;
    end

    // GF(2^8) arithmetic
    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc ^= x;
            x = gf_double(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        logic [15:0] d;
        d = {x, x} << n;
        return d[15:8];
    endfunction

    // Derive the S-box from the field inverse and the affine map
    function automatic void build_sboxes();
        logic [7:0] inv_v;
        logic [7:0] s;
        for (int a = 0; a < 256; a++)
        begin
            inv_v = 8'h00;
            for (int b = 1; b < 256; b++)
                if (a != 0 && gf_product(a[7:0], b[7:0]) == 8'h01)
                    inv_v = b[7:0];
            s = inv_v ^ rotl8(inv_v, 1) ^ rotl8(inv_v, 2) ^ rotl8(inv_v, 3)
                ^ rotl8(inv_v, 4) ^ 8'h63;
            sub_tab[a] = s;
            unsub_tab[s] = a[7:0];
        end
    endfunction

    function automatic logic [31:0] sub_word32(input logic [31:0] w);
        return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
    endfunction

    // Expand the shadow key into the 44-word schedule
    function automatic void expand_schedule();
        logic [7:0]  rcon;
        logic [31:0] t;
        rcon = 8'h01;
        sched_words[0] = key_hi_shadow[63:32];
        sched_words[1] = key_hi_shadow[31:0];
        sched_words[2] = key_lo_shadow[63:32];
        sched_words[3] = key_lo_shadow[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = sched_words[i - 1];
            if (i % 4 == 0)
            begin
                t = sub_word32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_double(rcon);
            end
            sched_words[i] = sched_words[i - 4] ^ t;
        end
    endfunction

    function automatic void add_round_key(input int r);
        for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
                st[4 * c + k] ^= sched_words[4 * r + c][31 - 8 * k -: 8];
    endfunction

    function automatic void sub_bytes(input logic inverse);
        for (int i = 0; i < 16; i++)
            st[i] = inverse ? unsub_tab[st[i]] : sub_tab[st[i]];
    endfunction

    // Rotate row k left by k (dir 1) or right by k (dir 3)
    function automatic void rotate_state_rows(input int dir);
        logic [7:0] t[16];
        for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
                t[4 * c + k] = st[4 * ((c + dir * k) & 3) + k];
        for (int i = 0; i < 16; i++)
            st[i] = t[i];
    endfunction

    function automatic void mix_columns(input logic inverse);
        logic [7:0] coef[4];
        logic [7:0] col[4];
        if (inverse)
            coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                col[k] = 8'h00;
                for (int j = 0; j < 4; j++)
                    col[k] ^= gf_product(st[4 * c + j], coef[(j - k) & 3]);
            end
            for (int k = 0; k < 4; k++)
                st[4 * c + k] = col[k];
        end
    endfunction

    // Compute the expected output block for one command
    function automatic block_pair_t aes_transform(input logic dir_bit, input logic [63:0] hi,
                                                  input logic [63:0] lo);
        block_pair_t res;
        for (int i = 0; i < 8; i++)
        begin
            st[i] = hi[63 - 8 * i -: 8];
            st[8 + i] = lo[63 - 8 * i -: 8];
        end
        if (dir_bit == OP_ENCRYPT)
        begin
            add_round_key(0);
            for (int r = 1; r <= 10; r++)
            begin
                sub_bytes(1'b0);
                rotate_state_rows(1);
                if (r != 10)
                    mix_columns(1'b0);
                add_round_key(r);
            end
        end
        else
        begin
            add_round_key(10);
            for (int r = 9; r >= 0; r--)
            begin
                rotate_state_rows(3);
                sub_bytes(1'b1);
                add_round_key(r);
                if (r != 0)
                    mix_columns(1'b1);
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            res.hi[63 - 8 * i -: 8] = st[i];
            res.lo[63 - 8 * i -: 8] = st[8 + i];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Biased random half-block: mostly random, sometimes an extreme
    function automatic logic [63:0] pick_half();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 64'h0;
        if (sel == 1)
            return '1;
        return rand64();
    endfunction

    function automatic void queue_block(input logic dir_bit, input logic [63:0] hi,
                                        input logic [63:0] lo);
        cmd_t c;
        c.kind = CMD_BLOCK;
        c.op_bit = dir_bit;
        c.reg_idx = CFG_KEY_HIGH;
        c.hi = hi;
        c.lo = lo;
        pending_cmds.push_back(c);
    endfunction

    function automatic void queue_key(input logic idx, input logic [63:0] val);
        cmd_t c;
        c.kind = CMD_KEY;
        c.op_bit = OP_ENCRYPT;
        c.reg_idx = idx;
        c.hi = val;
        c.lo = 64'h0;
        pending_cmds.push_back(c);
    endfunction

    function automatic void queue_drain();
        cmd_t c;
        c.kind = CMD_DRAIN;
        c.op_bit = OP_ENCRYPT;
        c.reg_idx = CFG_KEY_HIGH;
        c.hi = 64'h0;
        c.lo = 64'h0;
        pending_cmds.push_back(c);
    endfunction

    // Driver: start transfers and key writes from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        logic        accepted;
        logic        nxt_start;
        logic        nxt_cfg_we;
        logic        idle_now;
        int unsigned nxt_settle;
        cmd_t        c;
        if (!rst_n)
        begin
            start <= 1'b0;
            op <= OP_ENCRYPT;
            block_high <= 64'h0;
            block_low <= 64'h0;
            cfg_we <= 1'b0;
            cfg_index <= CFG_KEY_HIGH;
            cfg_data <= 64'h0;
            settle_cnt <= 0;
        end
        else
        begin
            accepted = start && !busy;
            nxt_start = start && !accepted;
            nxt_cfg_we = 1'b0;
            nxt_settle = (settle_cnt > 0) ? settle_cnt - 1 : 0;
            if (accepted)
            begin
                cipher_results_q.push_back(aes_transform(op, block_high, block_low));
                blocks_sent <= blocks_sent + 1;
            end
            // idle about 23% of cycles, but never while blocks_sent is in 700..1099
            idle_now = !(blocks_sent >= 700 && blocks_sent < 1100)
                       && ($urandom_range(0, 99) < 23);
            if (!nxt_start && !cfg_we && settle_cnt == 0 && pending_cmds.size() > 0 && !idle_now)
            begin
                c = pending_cmds[0];
                case (c.kind)
                    CMD_BLOCK:
                    begin
                        nxt_start = 1'b1;
                        op <= c.op_bit;
                        block_high <= c.hi;
                        block_low <= c.lo;
                        void'(pending_cmds.pop_front());
                    end
                    CMD_KEY:
                    begin
                        // write keys only with the cipher idle and nothing in flight
                        if (!accepted && !start && !busy && cipher_results_q.size() == 0)
                        begin
                            nxt_cfg_we = 1'b1;
                            cfg_index <= c.reg_idx;
                            cfg_data <= c.hi;
                            if (c.reg_idx == CFG_KEY_HIGH)
                                key_hi_shadow = c.hi;
                            else
                                key_lo_shadow = c.hi;
                            expand_schedule();
                            key_writes <= key_writes + 1;
                            nxt_settle = 3;
                            void'(pending_cmds.pop_front());
                        end
                    end
                    default:
                    begin
                        // hold off until every expected result is back
                        if (!accepted && !start && cipher_results_q.size() == 0)
                            void'(pending_cmds.pop_front());
                    end
                endcase
            end
            cfg_we <= nxt_cfg_we;
            settle_cnt <= nxt_settle;
            start <= nxt_start;
        end
    end

    // Monitor: compare each done strobe with the oldest expected block
    always @(posedge clk)
    begin
        block_pair_t exp_v;
        if (rst_n && done)
        begin
            if (cipher_results_q.size() == 0)
            begin
                $display("%0t: unexpected result %h_%h", $time, result_high, result_low);
                error_cnt++;
            end
            else
            begin
                exp_v = cipher_results_q.pop_front();
                results_seen++;
                if (result_high !== exp_v.hi)
                begin
                    $display("%0t: result_high expected %h actual %h", $time, exp_v.hi,
                             result_high);
                    error_cnt++;
                end
                if (result_low !== exp_v.lo)
                begin
                    $display("%0t: result_low expected %h actual %h", $time, exp_v.lo,
                             result_low);
                    error_cnt++;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, cipher_results_q.size());
            $display("tb_aes128_block_cipher: FAIL");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        cycle_cnt = 0;
        blocks_sent = 0;
        results_seen = 0;
        key_writes = 0;
        error_cnt = 0;
        key_hi_shadow = 64'h0;
        key_lo_shadow = 64'h0;
        build_sboxes();
        expand_schedule();

        // all-zero key, extreme blocks both ways
        queue_key(CFG_KEY_HIGH, 64'h0);
        queue_key(CFG_KEY_LOW, 64'h0);
        queue_block(OP_ENCRYPT, 64'h0, 64'h0);
        queue_block(OP_ENCRYPT, '1, '1);
        queue_block(OP_DECRYPT, 64'h0, 64'h0);
        queue_block(OP_DECRYPT, '1, '1);
        // all-ones key
        queue_key(CFG_KEY_HIGH, '1);
        queue_key(CFG_KEY_LOW, '1);
        queue_block(OP_ENCRYPT, 64'h0, 64'h0);
        queue_block(OP_DECRYPT, '1, '1);
        queue_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
        // standard known-answer vector
        queue_key(CFG_KEY_HIGH, 64'h0001020304050607);
        queue_key(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        queue_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        // half-written key: change only one register at a time
        queue_key(CFG_KEY_HIGH, 64'hffeeddccbbaa9988);
        queue_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_block(OP_DECRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_key(CFG_KEY_LOW, 64'h7766554433221100);
        queue_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        queue_block(OP_DECRYPT, '1, 64'h0);
        queue_drain();

        // random phases of 200 blocks; each key half is rewritten at a phase start in three of four cases
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 200 == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    queue_key(CFG_KEY_HIGH, pick_half());
                if ($urandom_range(0, 3) != 0)
                    queue_key(CFG_KEY_LOW, pick_half());
            end
            if (n == 1300)
                queue_drain();
            queue_block(1'($urandom_range(0, 1)), pick_half(), pick_half());
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() == 0 && cipher_results_q.size() == 0 && !start);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d cipher blocks (encrypt and decrypt) over %0d key register writes,",
                 blocks_sent, key_writes);
        $display("checked %0d results with %0d mismatches.", results_seen, error_cnt);
        if (error_cnt == 0 && cipher_results_q.size() == 0)
            $display("tb_aes128_block_cipher: PASS");
        else
            $display("tb_aes128_block_cipher: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_block_cipher.sv
sim/tb_aes128_block_cipher.sv
